>>> sv/lcsr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED current step regulator: shared package
// Duty, vote and configuration widths and constants used across the block.
// ----------------------------------------------------------------------------
package lcsr_pkg;

  localparam int unsigned DUTY_W = 10;
  localparam int unsigned VOTE_W = 3;
  localparam int unsigned CFG_W  = 12;

  typedef logic [DUTY_W-1:0]        duty_t;
  typedef logic signed [VOTE_W-1:0] vote_t;
  typedef logic [CFG_W-1:0]         cfg_t;

  localparam duty_t DUTY_MAX      = duty_t'(1023);
  localparam vote_t VOTE_HI       = 3'sd2;
  localparam vote_t VOTE_LO       = -3'sd2;
  localparam cfg_t  SET_POINT_RST = cfg_t'(700);

endpackage

>>> sv/lcsr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED current step regulator: window cell
// One tap of the sample window; passes its sample to the next cell on shift.
// ----------------------------------------------------------------------------
module lcsr_cell #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic [SAMPLE_BITS-1:0] data_i,
  output logic [SAMPLE_BITS-1:0] data_o
);

  logic [SAMPLE_BITS-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

>>> sv/lcsr_vote.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED current step regulator: vote and duty stage
// Steps the vote counter toward the error sign, moves the duty one count at
// each third vote, and holds the result in the output register.
// ----------------------------------------------------------------------------
module lcsr_vote #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [SAMPLE_BITS-1:0] avg_i,
  input  lcsr_pkg::cfg_t         set_point_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output lcsr_pkg::duty_t        duty_o,
  output logic [SAMPLE_BITS-1:0] avg_o
);

  localparam int unsigned CMP_W =
    (SAMPLE_BITS > lcsr_pkg::CFG_W) ? SAMPLE_BITS : lcsr_pkg::CFG_W;

  lcsr_pkg::vote_t        vote_q, vote_d;
  lcsr_pkg::duty_t        duty_q, duty_d;
  logic                   out_valid_q;
  lcsr_pkg::duty_t        duty_out_q;
  logic [SAMPLE_BITS-1:0] avg_out_q;
  logic [CMP_W-1:0]       avg_ext, sp_ext;
  logic                   load;

  assign avg_ext    = CMP_W'(avg_i);
  assign sp_ext     = CMP_W'(set_point_i);
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    vote_d = vote_q;
    duty_d = duty_q;
    if (avg_ext > sp_ext) begin
      if (vote_q == lcsr_pkg::VOTE_LO) begin
        vote_d = '0;
        if (duty_q != '0) begin
          duty_d = duty_q - lcsr_pkg::duty_t'(1);
        end
      end else begin
        vote_d = vote_q - lcsr_pkg::vote_t'(1);
      end
    end else if (avg_ext < sp_ext) begin
      if (vote_q == lcsr_pkg::VOTE_HI) begin
        vote_d = '0;
        if (duty_q != lcsr_pkg::DUTY_MAX) begin
          duty_d = duty_q + lcsr_pkg::duty_t'(1);
        end
      end else begin
        vote_d = vote_q + lcsr_pkg::vote_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vote_q      <= '0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        vote_q      <= vote_d;
        duty_q      <= duty_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      duty_out_q <= duty_d;
      avg_out_q  <= avg_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign duty_o      = duty_out_q;
  assign avg_o       = avg_out_q;

endmodule

>>> sv/led_current_step_regulator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED current step regulator
// Moving-average bang-bang loop: window average of sense samples drives a
// vote counter that steps the PWM duty up or down by one.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one sense sample per beat in tdata. m_axis returns one
//   beat per input beat: the duty after that step and the window average.
//   cfg_we_i/cfg_wdata_i write the set point; write it only while idle.
//   A sample passes three registered stages before it appears on m_axis
//   (running sum, average, output register).
//   Throughput is one beat per cycle while m_axis does not stall. The
//   running-sum and vote/duty updates are combinational ahead of their
//   registers; the window is a cell chain shifting once per accepted beat.
//   Reset clears every window cell to zero, the sum, the vote and the duty,
//   and loads the set point with 700.
//   When the receiver stalls, the output register holds its beat and the
//   two inner stages keep filling; s_axis_tready drops once all three
//   stages hold a beat, and rises again as soon as m_axis drains.
// ----------------------------------------------------------------------------
module led_current_step_regulator_unit #(
  parameter int unsigned WINDOW      = 50,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: sense_sample
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: duty_value, average_level
  output logic [((lcsr_pkg::DUTY_W+SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we_i,
  input  lcsr_pkg::cfg_t       cfg_wdata_i
);

  localparam int unsigned SUM_W  = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int unsigned MUL_W  = SHIFT + 1;
  localparam int unsigned PROD_W = SUM_W + MUL_W;
  localparam logic [63:0] RECIP_WIDE =
    ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [MUL_W-1:0] RECIP = RECIP_WIDE[MUL_W-1:0];

  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] chain [WINDOW+1];
  logic                   in_acc;
  logic                   ready2, ready3;

  lcsr_pkg::cfg_t         set_point_q;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic                   v1_q, v2_q;
  logic [PROD_W-1:0]      prod;
  logic [SAMPLE_BITS-1:0] avg_q;
  lcsr_pkg::duty_t        duty;
  logic [SAMPLE_BITS-1:0] avg_out;

  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
  assign ready2        = !v2_q || ready3;
  assign s_axis_tready = !v1_q || ready2;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // The window is a shift line: the tap at the far end is the sample that
  // leaves the window, zero until WINDOW beats have gone in.
  assign chain[0] = sample;
  for (genvar g = 0; g < WINDOW; g++) begin : g_cell
    lcsr_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(in_acc),
      .data_i (chain[g]),
      .data_o (chain[g+1])
    );
  end

  assign sum_d = sum_q + SUM_W'(sample) - SUM_W'(chain[WINDOW]);

  // Floor division by WINDOW through a rounded-up reciprocal; the shift is
  // wide enough that the quotient is exact over the whole sum range.
  assign prod = PROD_W'(sum_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_point_q <= lcsr_pkg::SET_POINT_RST;
      sum_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        set_point_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        sum_q <= sum_d;
        v1_q  <= 1'b1;
      end else if (ready2) begin
        v1_q  <= 1'b0;
      end
      if (v1_q && ready2) begin
        v2_q <= 1'b1;
      end else if (ready3) begin
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q && ready2) begin
      avg_q <= prod[SHIFT +: SAMPLE_BITS];
    end
  end

  lcsr_vote #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_vote (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (v2_q),
    .in_ready_o (ready3),
    .avg_i      (avg_q),
    .set_point_i(set_point_q),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .duty_o     (duty),
    .avg_o      (avg_out)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[lcsr_pkg::DUTY_W-1:0]           = duty;
    m_axis_tdata[lcsr_pkg::DUTY_W +: SAMPLE_BITS] = avg_out;
  end

endmodule

>>> sv/lcsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED current step regulator: port checker
// Watches the stream ports for held beats, duty steps and beats in flight.
// ----------------------------------------------------------------------------
module lcsr_port_checker #(
  parameter int unsigned TDATA_IN_W  = 16,
  parameter int unsigned TDATA_OUT_W = 24
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic [TDATA_IN_W-1:0]  s_axis_tdata,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready
);

  logic                  in_acc, out_acc;
  logic [2:0]            pending_q;
  logic                  seen_q;
  lcsr_pkg::duty_t       prev_duty_q;
  lcsr_pkg::duty_t       duty;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign duty    = m_axis_tdata[lcsr_pkg::DUTY_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      seen_q      <= 1'b0;
      prev_duty_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_acc) - 3'(out_acc);
      if (out_acc) begin
        seen_q      <= 1'b1;
        prev_duty_q <= duty;
      end
    end
  end

  // A beat that waits on the receiver keeps its data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");

  // The duty moves by at most one count from one result to the next.
  a_duty_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q && out_acc |->
      (duty == prev_duty_q) ||
      ({1'b0, duty} == {1'b0, prev_duty_q} + 11'd1) ||
      ({1'b0, prev_duty_q} == {1'b0, duty} + 11'd1))
    else $error("duty jumped by more than one count");

  // Three stages hold at most three beats.
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more beats in flight than pipeline stages");

  // No result without an accepted sample behind it.
  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 3'd0)
    else $error("output beat with no sample in flight");

  // A full pipeline with a stalled receiver takes no new sample.
  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd3 && !m_axis_tready |-> !s_axis_tready)
    else $error("sample taken while pipeline full");

endmodule

bind led_current_step_regulator_unit lcsr_port_checker #(
  .TDATA_IN_W ($bits(s_axis_tdata)),
  .TDATA_OUT_W($bits(m_axis_tdata))
) u_lcsr_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tdata (s_axis_tdata),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready)
);

>>> tb/lcsr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED current step regulator: stream checker
// Watches the sample, result and set point ports. It keeps its own model of
// the averaging window, the vote counter and the duty. Each result beat is
// compared field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module lcsr_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  // tdata: sense_sample
  input  logic [15:0]    s_axis_tdata,
  input  logic           s_axis_tvalid,
  input  logic           s_axis_tready,
  // tdata: duty_value, average_level
  input  logic [23:0]    m_axis_tdata,
  input  logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  input  logic           cfg_we_i,
  input  lcsr_pkg::cfg_t cfg_wdata_i,
  output int             fail_count_o,
  output int             pending_o,
  output int             beats_seen_o,
  output int             steps_up_o,
  output int             steps_down_o,
  output int             level_hits_o
);

  localparam int unsigned WINDOW_LEN = 50;

  typedef struct packed {
    lcsr_pkg::duty_t duty;
    logic [11:0]     level;
  } regulation_t;

  regulation_t regulation_q[$];

  logic [11:0]     window_mem [WINDOW_LEN];
  logic [5:0]      slot_ptr;
  logic [17:0]     window_sum;
  lcsr_pkg::vote_t tally;
  lcsr_pkg::duty_t duty_now;
  lcsr_pkg::cfg_t  target_level;

  task automatic track_sample(input logic [11:0] sample);
    logic [11:0] level;
    begin
      window_sum = window_sum - window_mem[slot_ptr] + sample;
      window_mem[slot_ptr] = sample;
      slot_ptr = (slot_ptr == WINDOW_LEN - 1) ? 6'd0 : slot_ptr + 6'd1;
      level = 12'(window_sum / WINDOW_LEN);
      if (level > target_level) begin
        tally = tally - lcsr_pkg::vote_t'(1);
        if (tally < lcsr_pkg::VOTE_LO) begin
          if (duty_now != '0) duty_now = duty_now - lcsr_pkg::duty_t'(1);
          tally = '0;
          steps_down_o++;
        end
      end else if (level < target_level) begin
        tally = tally + lcsr_pkg::vote_t'(1);
        if (tally > lcsr_pkg::VOTE_HI) begin
          if (duty_now != lcsr_pkg::DUTY_MAX) duty_now = duty_now + lcsr_pkg::duty_t'(1);
          tally = '0;
          steps_up_o++;
        end
      end else begin
        level_hits_o++;
      end
      regulation_q.push_back('{duty: duty_now, level: level});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    regulation_t want;
    logic [9:0]  got_duty;
    logic [11:0] got_level;
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) window_mem[i] = '0;
      slot_ptr     = '0;
      window_sum   = '0;
      tally        = '0;
      duty_now     = '0;
      target_level = lcsr_pkg::SET_POINT_RST;
      regulation_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      beats_seen_o = 0;
      steps_up_o   = 0;
      steps_down_o = 0;
      level_hits_o = 0;
    end else begin
      if (cfg_we_i) target_level = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) track_sample(s_axis_tdata[11:0]);
      if (m_axis_tvalid && m_axis_tready) begin
        got_duty  = m_axis_tdata[9:0];
        got_level = m_axis_tdata[21:10];
        beats_seen_o++;
        if (regulation_q.size() == 0) begin
          $display("%0t: result beat with nothing expected: duty %0d level %0d",
                   $time, got_duty, got_level);
          fail_count_o++;
        end else begin
          want = regulation_q.pop_front();
          if (got_duty !== want.duty) begin
            $display("%0t: duty_value expected %0d actual %0d",
                     $time, want.duty, got_duty);
            fail_count_o++;
          end
          if (got_level !== want.level) begin
            $display("%0t: average_level expected %0d actual %0d",
                     $time, want.level, got_level);
            fail_count_o++;
          end
        end
      end
      pending_o = regulation_q.size();
    end
  end

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LED current step regulator: testbench top
// Drives sense samples and set point writes with random gaps and receiver
// stalls, including one long stall. It holds the duty against its floor and
// takes the verdict from the checker.
// ----------------------------------------------------------------------------
module testbench;

  logic           clk_i;
  logic           rst_ni;
  logic [15:0]    s_axis_tdata;
  logic           s_axis_tvalid;
  logic           s_axis_tready;
  logic [23:0]    m_axis_tdata;
  logic           m_axis_tvalid;
  logic           m_axis_tready;
  logic           cfg_we_i;
  lcsr_pkg::cfg_t cfg_wdata_i;

  int fail_count;
  int pending;
  int beats_seen;
  int steps_up;
  int steps_down;
  int level_hits;
  int samples_sent;
  int targets_used;
  bit quiet_phase;
  bit long_hold_done;

  led_current_step_regulator_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  lcsr_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .beats_seen_o  (beats_seen),
    .steps_up_o    (steps_up),
    .steps_down_o  (steps_down),
    .level_hits_o  (level_hits)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (quiet_phase) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat.
  task automatic send_sample(input int value);
    int gap;
    begin
      gap = pick_gap();
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= {4'b0, value[11:0]};
      @(posedge clk_i);
      while (!s_axis_tready) @(posedge clk_i);
      samples_sent++;
      @(negedge clk_i);
    end
  endtask

  // The set point may only change once the pipeline has drained.
  task automatic write_target(input int value);
    begin
      s_axis_tvalid <= 1'b0;
      while (pending != 0) @(negedge clk_i);
      repeat (4) @(negedge clk_i);
      cfg_we_i    <= 1'b1;
      cfg_wdata_i <= lcsr_pkg::cfg_t'(value);
      @(negedge clk_i);
      cfg_we_i <= 1'b0;
      targets_used++;
      @(negedge clk_i);
    end
  endtask

  // Receiver: random stalls, plus one long hold while samples keep coming.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (!long_hold_done && beats_seen >= 300) begin
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (80) @(negedge clk_i);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        m_axis_tready <= 1'b1;
        @(negedge clk_i);
      end
    end
  end

  initial begin
    int target;
    int value;
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tvalid = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    samples_sent  = 0;
    targets_used  = 0;
    quiet_phase   = 1'b0;
    long_hold_done = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Default set point, then the field extremes.
    send_sample(700);
    send_sample(4095);
    send_sample(0);

    // Target of zero: earlier samples still in the window keep the average above
    // target, so the zeros vote the duty down to zero, then full-scale samples vote down while it sits there.
    write_target(0);
    repeat (3) send_sample(0);
    repeat (7) send_sample(4095);

    write_target(4095);
    send_sample('hAAA);
    send_sample('h555);
    send_sample(1);
    send_sample('h800);
    send_sample('h7FF);
    send_sample(4095);
    send_sample(0);

    // Random phases: mostly samples close to the target so the loop
    // hunts around it, with some full-range noise.
    for (int phase = 0; phase < 9; phase++) begin
      case (phase)
        0:       target = 0;
        1:       target = 4095;
        2:       target = 2048;
        default: target = $urandom_range(0, 4095);
      endcase
      write_target(target);
      quiet_phase = (phase == 4);
      for (int n = 0; n < 90; n++) begin
        if (phase == 2) begin
          value = 2048;
        end else if ($urandom_range(0, 9) < 7) begin
          value = target + $urandom_range(0, 80) - 40;
          if (value < 0) value = 0;
          if (value > 4095) value = 4095;
        end else begin
          value = $urandom_range(0, 4095);
        end
        send_sample(value);
      end
    end
    quiet_phase = 1'b0;

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Sent %0d sense samples over %0d set point writes, %0d results checked.",
             samples_sent, targets_used, beats_seen);
    $display("Duty stepped up %0d and down %0d times; average on target %0d times.",
             steps_up, steps_down, level_hits);
    if (fail_count == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/lcsr_pkg.sv
sv/lcsr_cell.sv
sv/lcsr_vote.sv
sv/led_current_step_regulator_unit.sv
sv/lcsr_checker.sv
tb/lcsr_checker.sv
tb/testbench.sv
